@@ hdl/sbhp_pkg.sv @@
// Shared types, constants and arithmetic helpers for the spectral bin high-pass filter.
package sbhp_pkg;

  typedef struct packed {
    logic [9:0]         row_index;
    logic [9:0]         col_index;
    logic signed [31:0] bin_re;
    logic signed [31:0] bin_im;
    logic signed [31:0] coef_re;
    logic signed [31:0] coef_im;
    logic               last_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic               last_out;
  } out_t;

  typedef enum logic [2:0] {
    REG_MATCHED_ON     = 3'd0,
    REG_HIPASS_ON      = 3'd1,
    REG_ROW_COUNT      = 3'd2,
    REG_PASS_RADIUS_SQ = 3'd3,
    REG_STOP_RADIUS_SQ = 3'd4,
    REG_PASS_RADIUS_Q8 = 3'd5,
    REG_GAUSS_RATE     = 3'd6,
    REG_NORM_SCALE     = 3'd7
  } cfg_reg_t;

  localparam logic [30:0] LOG2E_Q30     = 31'd1549082005;
  localparam logic [38:0] EXP_LIMIT_Q16 = 39'd1572864;
  localparam logic [32:0] GAIN_ONE      = 33'h1_0000_0000;

  // floor square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bval;
    rem  = v;
    res  = '0;
    bval = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bval) begin
        rem = rem - (res + bval);
        res = (res >> 1) + bval;
      end else begin
        res = res >> 1;
      end
      bval = bval >> 2;
    end
    return res;
  endfunction

  // 2^-(2^-(k+1)) in Q32, by repeated floor square roots of one half
  function automatic logic [31:0] half_root(input int k);
    logic [63:0] t;
    t = 64'd1 << 31;
    for (int j = 0; j <= k; j++) begin
      t = isqrt64(t << 32);
    end
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -68'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // round half up, drop 32 fraction bits, saturate
  function automatic logic signed [31:0] rsat_q32(input logic signed [65:0] p);
    logic signed [66:0] t;
    t = {p[65], p} + 67'sd2147483648;
    return sat32(68'(t >>> 32));
  endfunction

  // round half up, drop 30 fraction bits, saturate
  function automatic logic signed [31:0] rsat_q30(input logic signed [64:0] p);
    logic signed [65:0] t;
    t = {p[64], p} + 66'sd536870912;
    return sat32(68'(t >>> 30));
  endfunction

endpackage

@@ hdl/sbhp_isqrt.sv @@
// Pipelined floor square root of d2 scaled by 2^16, one root bit per stage.
module sbhp_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [20:0] d2,
  output logic [18:0] root
);

  localparam int NSTEP = 19;
  localparam int RW    = 39;

  logic [RW-1:0] rem_r [NSTEP];
  logic [18:0]   q_r   [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam int K = NSTEP - 1 - i;
    logic [RW-1:0] rem_in;
    logic [RW-1:0] trial;
    logic [18:0]   q_in;

    if (i == 0) begin : g_first
      assign rem_in = {2'b00, d2, 16'h0000};
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
    end

    // (q + 2^k)^2 - q^2
    assign trial = ({20'h0, q_in} << (K + 1)) + (RW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[i] <= rem_in - trial;
          q_r[i]   <= q_in | (19'd1 << K);
        end else begin
          rem_r[i] <= rem_in;
          q_r[i]   <= q_in;
        end
      end
    end
  end

  assign root = q_r[NSTEP-1];

endmodule

@@ hdl/sbhp_gain.sv @@
// Pipelined Gaussian apodisation gain exp(-rate*(r_pass - r)^2) in Q32.
module sbhp_gain (
  input  logic        clk,
  input  logic        en,
  input  logic [18:0] root,
  input  logic [17:0] pass_q8,
  input  logic [31:0] gauss,
  output logic [32:0] gain
);

  localparam int NBIT = 16;

  logic [18:0] e_r;
  logic [37:0] e2_r;
  logic [53:0] p1_r;
  logic [47:0] p2_r;
  logic [20:0] x_r;
  logic        ov1_r;
  logic [51:0] yp_r;
  logic        ov2_r;
  logic [5:0]  n_r;
  logic [15:0] f_r;
  logic        ov3_r;
  logic [32:0] g_r   [NBIT];
  logic [5:0]  nc_r  [NBIT];
  logic [15:0] fc_r  [NBIT];
  logic        ovc_r [NBIT];
  logic [32:0] gain_r;

  logic [54:0] xs;
  logic [38:0] x_full;
  logic [51:0] ysum;
  logic [33:0] sh_half;
  logic [33:0] sh_sum;
  logic [33:0] sh_res;

  assign xs     = {1'b0, p1_r} + 55'(p2_r >> 16);
  assign x_full = xs[54:16];
  assign ysum   = yp_r + 52'd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      e_r   <= (root >= {1'b0, pass_q8}) ? root - {1'b0, pass_q8} : {1'b0, pass_q8} - root;
      e2_r  <= e_r * e_r;
      p1_r  <= gauss * e2_r[37:16];
      p2_r  <= gauss * e2_r[15:0];
      x_r   <= x_full[20:0];
      ov1_r <= (x_full >= sbhp_pkg::EXP_LIMIT_Q16);
      yp_r  <= x_r * sbhp_pkg::LOG2E_Q30;
      ov2_r <= ov1_r;
      n_r   <= ysum[51:46];
      f_r   <= ysum[45:30];
      ov3_r <= ov2_r;
    end
  end

  for (genvar i = 0; i < NBIT; i++) begin : g_root
    localparam logic [31:0] ROOT = sbhp_pkg::half_root(i);
    logic [32:0] g_in;
    logic [5:0]  n_in;
    logic [15:0] f_in;
    logic        ov_in;
    logic [64:0] prod;

    if (i == 0) begin : g_first
      assign g_in  = sbhp_pkg::GAIN_ONE;
      assign n_in  = n_r;
      assign f_in  = f_r;
      assign ov_in = ov3_r;
    end else begin : g_next
      assign g_in  = g_r[i-1];
      assign n_in  = nc_r[i-1];
      assign f_in  = fc_r[i-1];
      assign ov_in = ovc_r[i-1];
    end

    assign prod = g_in * ROOT + 65'd2147483648;

    always_ff @(posedge clk) begin
      if (en) begin
        g_r[i]   <= f_in[NBIT-1-i] ? prod[64:32] : g_in;
        nc_r[i]  <= n_in;
        fc_r[i]  <= f_in;
        ovc_r[i] <= ov_in;
      end
    end
  end

  // integer part of the exponent: rounded right shift
  assign sh_half = (34'd1 << nc_r[NBIT-1]) >> 1;
  assign sh_sum  = {1'b0, g_r[NBIT-1]} + sh_half;
  assign sh_res  = sh_sum >> nc_r[NBIT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovc_r[NBIT-1] || nc_r[NBIT-1] >= 6'd33) begin
        gain_r <= '0;
      end else begin
        gain_r <= sh_res[32:0];
      end
    end
  end

  assign gain = gain_r;

endmodule

@@ hdl/spectral_bin_highpass_matched_filter_unit.sv @@
// Top level of the spectral bin high-pass and matched filter.
//
// Input channel in_valid/in_ready/in_data carries one spectral bin with its
// matched-filter coefficient; the result channel out_valid/out_ready/out_data
// returns the filtered bin with the last flag copied. The cfg channel writes
// one of eight registers (cfg_index, cfg_data); cfg_ready is always high and
// registers should only change while no bin is in flight.
// One bin is taken every cycle while out_ready is high or the output stage is
// empty. The depth is set by the square root (one bit per stage) and the
// sixteen-step exponential gain chain, each gain step holding one multiply.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults. When the receiver stalls, the whole pipeline holds and in_ready
// drops, so no bin is lost or repeated.
module spectral_bin_highpass_matched_filter_unit #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sbhp_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sbhp_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int          NST      = 50;
  localparam int          NSIDE    = 42;
  localparam logic [12:0] ROWS_CAP = 13'(MAX_ROWS);
  localparam logic [11:0] COL_CAP  = 12'(MAX_COLS / 2);

  typedef enum logic [1:0] {GS_UNITY, GS_ZERO, GS_BAND} gsel_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               last;
    logic               zb;
    gsel_t              gsel;
    logic               nrm;
  } side_t;

  // configuration
  logic        matched_on_r;
  logic        hipass_on_r;
  logic [10:0] row_count_r;
  logic [19:0] pass_sq_r;
  logic [19:0] stop_sq_r;
  logic [17:0] pass_q8_r;
  logic [31:0] gauss_r;
  logic [31:0] norm_r;

  logic adv;
  logic vld_r [NST];

  sbhp_pkg::in_t      in_r;
  logic signed [63:0] prr_r, pii_r, pir_r, pri_r;
  logic [9:0]         fr_r, col_r;
  logic signed [31:0] s2_re_r, s2_im_r;
  logic               s2_last_r, s2_zb_r;
  logic signed [31:0] s3_re_r, s3_im_r;
  logic               s3_last_r, s3_zb_r;
  logic [20:0]        d2_r;
  side_t              side_r [NSIDE];
  side_t              side_in;

  logic [18:0] root_w;
  logic [32:0] gain_w;

  logic signed [31:0] t1_re_r, t1_im_r, t3_re_r, t3_im_r;
  logic               t1_last_r, t1_zb_r, t1_nrm_r;
  logic [32:0]        t1_g_r;
  logic signed [65:0] t2_re_r, t2_im_r, t4_re_r, t4_im_r;
  logic               t2_last_r, t2_zb_r, t2_nrm_r;
  logic               t3_last_r, t3_zb_r, t3_nrm_r;
  logic               t4_last_r, t4_zb_r;
  sbhp_pkg::out_t     out_r;

  logic [12:0] rc;
  logic [12:0] row13;
  logic [9:0]  fr;
  logic [9:0]  colc;
  logic [32:0] g_sel;
  logic [32:0] nfac;
  logic signed [64:0] mre, mim;

  assign adv       = !vld_r[NST-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_on_r <= 1'b0;
      hipass_on_r  <= 1'b1;
      row_count_r  <= 11'd1024;
      pass_sq_r    <= '0;
      stop_sq_r    <= '0;
      pass_q8_r    <= '0;
      gauss_r      <= '0;
      norm_r       <= 32'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbhp_pkg::REG_MATCHED_ON:     matched_on_r <= cfg_data[0];
        sbhp_pkg::REG_HIPASS_ON:      hipass_on_r  <= cfg_data[0];
        sbhp_pkg::REG_ROW_COUNT:      row_count_r  <= cfg_data[10:0];
        sbhp_pkg::REG_PASS_RADIUS_SQ: pass_sq_r    <= cfg_data[19:0];
        sbhp_pkg::REG_STOP_RADIUS_SQ: stop_sq_r    <= cfg_data[19:0];
        sbhp_pkg::REG_PASS_RADIUS_Q8: pass_q8_r    <= cfg_data[17:0];
        sbhp_pkg::REG_GAUSS_RATE:     gauss_r      <= cfg_data;
        sbhp_pkg::REG_NORM_SCALE:     norm_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // row fold and column clamp
  always_comb begin
    rc    = (13'(row_count_r) > ROWS_CAP) ? ROWS_CAP : 13'(row_count_r);
    row13 = 13'(in_r.row_index);
    if (row13 <= (rc >> 1)) begin
      fr = in_r.row_index;
    end else if (row13 < rc) begin
      fr = 10'(rc - row13);
    end else begin
      fr = 10'(row13 - rc);
    end
    colc = (12'(in_r.col_index) > COL_CAP) ? COL_CAP[9:0] : in_r.col_index;
  end

  assign mre = {prr_r[63], prr_r} - {pii_r[63], pii_r};
  assign mim = {pir_r[63], pir_r} + {pri_r[63], pri_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r      <= in_data;
      prr_r     <= $signed(in_r.bin_re) * $signed(in_r.coef_re);
      pii_r     <= $signed(in_r.bin_im) * $signed(in_r.coef_im);
      pir_r     <= $signed(in_r.bin_im) * $signed(in_r.coef_re);
      pri_r     <= $signed(in_r.bin_re) * $signed(in_r.coef_im);
      fr_r      <= fr;
      col_r     <= colc;
      s2_re_r   <= in_r.bin_re;
      s2_im_r   <= in_r.bin_im;
      s2_last_r <= in_r.last_in;
      s2_zb_r   <= (in_r.row_index == '0) && (in_r.col_index == '0);
      s3_re_r   <= matched_on_r ? sbhp_pkg::rsat_q30(mre) : s2_re_r;
      s3_im_r   <= matched_on_r ? sbhp_pkg::rsat_q30(mim) : s2_im_r;
      s3_last_r <= s2_last_r;
      s3_zb_r   <= s2_zb_r;
      d2_r      <= 21'(fr_r * fr_r) + 21'(col_r * col_r);
    end
  end

  always_comb begin
    side_in.re   = s3_re_r;
    side_in.im   = s3_im_r;
    side_in.last = s3_last_r;
    side_in.zb   = s3_zb_r;
    side_in.nrm  = hipass_on_r && !matched_on_r;
    if (!hipass_on_r || d2_r > 21'(pass_sq_r)) begin
      side_in.gsel = GS_UNITY;
    end else if (gauss_r != '0 && d2_r > 21'(stop_sq_r)) begin
      side_in.gsel = GS_BAND;
    end else begin
      side_in.gsel = GS_ZERO;
    end
  end

  // hold the bin alongside the root and gain pipelines
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < NSIDE; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  sbhp_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .d2   (d2_r),
    .root (root_w)
  );

  sbhp_gain u_gain (
    .clk     (clk),
    .en      (adv),
    .root    (root_w),
    .pass_q8 (pass_q8_r),
    .gauss   (gauss_r),
    .gain    (gain_w)
  );

  always_comb begin
    case (side_r[NSIDE-1].gsel)
      GS_ZERO: g_sel = '0;
      GS_BAND: g_sel = gain_w;
      default: g_sel = sbhp_pkg::GAIN_ONE;
    endcase
    nfac = t3_nrm_r ? {1'b0, norm_r} : sbhp_pkg::GAIN_ONE;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_g_r    <= g_sel;
      t1_re_r   <= side_r[NSIDE-1].re;
      t1_im_r   <= side_r[NSIDE-1].im;
      t1_last_r <= side_r[NSIDE-1].last;
      t1_zb_r   <= side_r[NSIDE-1].zb;
      t1_nrm_r  <= side_r[NSIDE-1].nrm;
      t2_re_r   <= 66'($signed(t1_re_r) * $signed({1'b0, t1_g_r}));
      t2_im_r   <= 66'($signed(t1_im_r) * $signed({1'b0, t1_g_r}));
      t2_last_r <= t1_last_r;
      t2_zb_r   <= t1_zb_r;
      t2_nrm_r  <= t1_nrm_r;
      t3_re_r   <= sbhp_pkg::rsat_q32(t2_re_r);
      t3_im_r   <= sbhp_pkg::rsat_q32(t2_im_r);
      t3_last_r <= t2_last_r;
      t3_zb_r   <= t2_zb_r;
      t3_nrm_r  <= t2_nrm_r;
      t4_re_r   <= 66'($signed(t3_re_r) * $signed({1'b0, nfac}));
      t4_im_r   <= 66'($signed(t3_im_r) * $signed({1'b0, nfac}));
      t4_last_r <= t3_last_r;
      t4_zb_r   <= t3_zb_r;
      out_r.out_re   <= t4_zb_r ? '0 : sbhp_pkg::rsat_q32(t4_re_r);
      out_r.out_im   <= t4_zb_r ? '0 : sbhp_pkg::rsat_q32(t4_im_r);
      out_r.last_out <= t4_last_r;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // the gain leaves its pipeline beside the bin held in the last side stage
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSIDE+2] |-> (gain_w <= sbhp_pkg::GAIN_ONE))
    else $error("apodisation gain above one");

  a_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[NST-2] && t4_zb_r) |=> (out_data.out_re == '0 && out_data.out_im == '0))
    else $error("bin zero not cleared");

endmodule
